// File: rtl/clut_pkg.sv
// Shared types and constants for the circular log unread tracker.
package clut_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int REC_W = 80;

  typedef enum logic [1:0] {
    KIND_SAVE = 2'd0,
    KIND_READ = 2'd1,
    KIND_MARK = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        clock_synced;
    logic [31:0] stamp;
    logic [31:0] volume;
    logic [15:0] meter_status;
    logic [6:0]  offset;
  } in_t;

  typedef struct packed {
    logic [6:0]  op_value;
    logic [31:0] entry_stamp;
    logic [31:0] entry_volume;
    logic [15:0] entry_status;
    logic [6:0]  stored_total;
    logic [6:0]  reported_unread;
  } out_t;

endpackage

// File: rtl/clut_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/circular_log_unread_tracker.sv
// Ring log of records with write position and saturating stored/unread counts.
// The result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless the result stalls; the single registered RAM read port sets this.
// A stalled result holds; the next item is taken in the cycle the result leaves.
// Reset clears write position and both counts; record contents stay undefined.
module circular_log_unread_tracker #(
  parameter int CAPACITY = clut_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  clut_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output clut_pkg::out_t out_data_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = ((CW > 7) ? CW : 7) + 1;

  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] unread_q, unread_d;
  logic [CW-1:0] held_q, held_d;

  logic          s1_valid_q;
  logic          found_q, found_d;
  logic [6:0]    op_q, op_d;
  logic [6:0]    stored_q, stored_d;
  logic [6:0]    reported_q, reported_d;

  logic          accept;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [clut_pkg::REC_W-1:0] ram_rdata;

  logic [W-1:0]  unread_w, offset_w, rd_off_w, mk_off_w, op_w, held_w, rep_w;
  logic [CW-1:0] back;
  logic [AW:0]   wp_x, back_x, start_x, sum_x, idx_x;

  assign in_ready_o = !s1_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign unread_w = W'(unread_q);
  assign offset_w = W'(in_data_i.offset);

  // Locate the record at the clamped offset past the oldest unread one, or the newest record when nothing is unread.
  always_comb begin
    back     = (unread_q == '0) ? CW'(1) : unread_q;
    wp_x     = {1'b0, wp_q};
    back_x   = (AW+1)'(back);
    start_x  = (wp_x >= back_x) ? (wp_x - back_x)
                                : (wp_x + (AW+1)'(CAPACITY) - back_x);
    if (unread_q == '0) begin
      rd_off_w = '0;
    end else if (offset_w >= unread_w) begin
      rd_off_w = unread_w - W'(1);
    end else begin
      rd_off_w = offset_w;
    end
    sum_x     = start_x + (AW+1)'(rd_off_w);
    idx_x     = (sum_x >= (AW+1)'(CAPACITY)) ? (sum_x - (AW+1)'(CAPACITY)) : sum_x;
    ram_raddr = idx_x[AW-1:0];
    mk_off_w  = (offset_w > unread_w) ? unread_w : offset_w;
  end

  always_comb begin
    wp_d     = wp_q;
    unread_d = unread_q;
    held_d   = held_q;
    found_d  = 1'b0;
    op_w     = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    unique case (in_data_i.kind)
      clut_pkg::KIND_SAVE: begin
        if (in_data_i.clock_synced) begin
          ram_we   = accept;
          wp_d     = (wp_q == AW'(CAPACITY - 1)) ? '0 : wp_q + AW'(1);
          held_d   = (held_q < CW'(CAPACITY)) ? held_q + CW'(1) : held_q;
          unread_d = (unread_q < CW'(CAPACITY)) ? unread_q + CW'(1) : unread_q;
          op_w     = W'(unread_d);
        end
      end
      clut_pkg::KIND_READ: begin
        if (held_q != '0) begin
          ram_re  = accept;
          found_d = 1'b1;
          op_w    = W'(1);
        end
      end
      clut_pkg::KIND_MARK: begin
        if (in_data_i.offset != '0 && held_q != '0) begin
          unread_d = unread_q - CW'(mk_off_w);
          op_w     = W'(unread_d);
        end
      end
      default: begin
      end
    endcase
    held_w     = W'(held_d);
    rep_w      = (held_d == '0) ? '0 : ((unread_d == '0) ? W'(1) : W'(unread_d));
    op_d       = op_w[6:0];
    stored_d   = held_w[6:0];
    reported_d = rep_w[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      unread_q   <= '0;
      held_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q     <= wp_d;
        unread_q <= unread_d;
        held_q   <= held_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q    <= found_d;
      op_q       <= op_d;
      stored_q   <= stored_d;
      reported_q <= reported_d;
    end
  end

  clut_ram #(
    .WIDTH (clut_pkg::REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({in_data_i.stamp, in_data_i.volume, in_data_i.meter_status}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o                = s1_valid_q;
  assign out_data_o.op_value        = op_q;
  assign out_data_o.entry_stamp     = found_q ? ram_rdata[79:48] : '0;
  assign out_data_o.entry_volume    = found_q ? ram_rdata[47:16] : '0;
  assign out_data_o.entry_status    = found_q ? ram_rdata[15:0]  : '0;
  assign out_data_o.stored_total    = stored_q;
  assign out_data_o.reported_unread = reported_q;

  a_unread_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unread_q <= held_q)
    else $error("unread count exceeds stored count");

  a_held_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_read_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && found_q) |=> $stable(ram_rdata))
    else $error("stalled read result lost its record");

endmodule
